// ----- hdl/b32m_pkg.sv -----
package b32m_pkg;

  localparam int unsigned ExpW   = 8;
  localparam int unsigned FracW  = 23;
  localparam int unsigned SigW   = FracW + 1;
  localparam int unsigned ProdW  = 2 * SigW;
  localparam int unsigned Bias   = 127;
  localparam logic [31:0] DefaultNan = 32'h7FC0_0000;
  localparam logic [31:0] QuietBit   = 32'h0040_0000;
  localparam logic [30:0] InfMag     = 31'h7F80_0000;

  // special-case class decided in the unpack stage
  typedef enum logic [2:0] {
    SPC_NONE,
    SPC_NAN_A,
    SPC_NAN_B,
    SPC_DNAN,
    SPC_INF,
    SPC_ZERO
  } spc_e;

  typedef struct packed {
    logic        sign;
    spc_e        spc;
    logic [31:0] nan_val;
    logic [9:0]  exp_sum;   // xa + xb, unsigned
  } ctl_t;

  // index of the leading one in a 48-bit product (0 when zero)
  function automatic logic [5:0] lead_idx(input logic [ProdW-1:0] v);
    logic [5:0] idx;
    idx = '0;
    for (int i = 0; i < ProdW; i++) begin
      if (v[i]) idx = 6'(i);
    end
    return idx;
  endfunction

endpackage

// ----- hdl/binary32_multiplier.sv -----
// channel | direction | tdata fields (low bit up)                 | tuser
// s_axis  | in        | operand_a[31:0], operand_b[63:32]         | -
// m_axis  | out       | product[31:0], overflowed[32], underflowed[33] | -
//
// four register stages: unpack, 24x24 multiply, normalize/align, round
// one transaction accepted per cycle while the output is not stalled
// the whole pipe advances when the output slot is empty or being taken
// reset clears the valid bits only; payload registers are not reset
module binary32_multiplier import b32m_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // operand_a, operand_b
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // product, overflowed, underflowed, zero fill
);
  logic advance;
  logic v1_q, v2_q, v3_q, v4_q;

  // stage 1: unpacked operands
  ctl_t            ctl1_d, ctl1_q, ctl2_q, ctl3_q;
  logic [SigW-1:0] ma_d, mb_d, ma_q, mb_q;
  // stage 2: raw product
  logic [ProdW-1:0] prod_q;
  // stage 3: aligned significand
  logic [ProdW-1:0]   mant_d, mant_q;
  logic               guard_d, sticky_d, normal_d, guard_q, sticky_q, normal_q;
  logic signed [11:0] expo_d, expo_q;
  // stage 4: packed result
  logic [31:0] product_d, product_q;
  logic        ovf_d, unf_d, ovf_q, unf_q;

  // a stall freezes every stage, so nothing is lost or repeated
  assign advance       = !v4_q || m_axis_tready;
  assign s_axis_tready = advance;

  b32m_unpack u_unpack (
    .a_i(s_axis_tdata[31:0]), .b_i(s_axis_tdata[63:32]),
    .ctl_o(ctl1_d), .ma_o(ma_d), .mb_o(mb_d)
  );

  b32m_align u_align (
    .prod_i(prod_q), .exp_sum_i(ctl2_q.exp_sum),
    .mant_o(mant_d), .guard_o(guard_d), .sticky_o(sticky_d),
    .normal_o(normal_d), .expo_o(expo_d)
  );

  b32m_round u_round (
    .ctl_i(ctl3_q), .mant_i(mant_q), .guard_i(guard_q), .sticky_i(sticky_q),
    .normal_i(normal_q), .expo_i(expo_q),
    .product_o(product_d), .ovf_o(ovf_d), .unf_o(unf_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (advance) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ctl1_q    <= ctl1_d;
      ma_q      <= ma_d;
      mb_q      <= mb_d;
      ctl2_q    <= ctl1_q;
      prod_q    <= ProdW'(ma_q) * ProdW'(mb_q);
      ctl3_q    <= ctl2_q;
      mant_q    <= mant_d;
      guard_q   <= guard_d;
      sticky_q  <= sticky_d;
      normal_q  <= normal_d;
      expo_q    <= expo_d;
      product_q <= product_d;
      ovf_q     <= ovf_d;
      unf_q     <= unf_d;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {6'd0, unf_q, ovf_q, product_q};
endmodule

// ----- hdl/b32m_unpack.sv -----
module b32m_unpack import b32m_pkg::*; (
  input  logic [31:0]     a_i,
  input  logic [31:0]     b_i,
  output ctl_t            ctl_o,
  output logic [SigW-1:0] ma_o,
  output logic [SigW-1:0] mb_o
);
  logic [ExpW-1:0] ea, eb;
  logic nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;

  always_comb begin
    ea     = a_i[30:23];
    eb     = b_i[30:23];
    nan_a  = (ea == 8'hFF) && (a_i[22:0] != '0);
    nan_b  = (eb == 8'hFF) && (b_i[22:0] != '0);
    inf_a  = (ea == 8'hFF) && (a_i[22:0] == '0);
    inf_b  = (eb == 8'hFF) && (b_i[22:0] == '0);
    zero_a = (ea == '0) && (a_i[22:0] == '0);
    zero_b = (eb == '0) && (b_i[22:0] == '0);
    ctl_o.sign    = a_i[31] ^ b_i[31];
    ctl_o.nan_val = nan_a ? (a_i | QuietBit) : (b_i | QuietBit);
    ctl_o.exp_sum = 10'((ea == '0) ? 8'd1 : ea) + 10'((eb == '0) ? 8'd1 : eb);
    priority if (nan_a)                                 ctl_o.spc = SPC_NAN_A;
    else if (nan_b)                                     ctl_o.spc = SPC_NAN_B;
    else if ((inf_a && zero_b) || (inf_b && zero_a))    ctl_o.spc = SPC_DNAN;
    else if (inf_a || inf_b)                            ctl_o.spc = SPC_INF;
    else if (zero_a || zero_b)                          ctl_o.spc = SPC_ZERO;
    else                                                ctl_o.spc = SPC_NONE;
    ma_o = {(ea != '0), a_i[22:0]};
    mb_o = {(eb != '0), b_i[22:0]};
  end
endmodule

// ----- hdl/b32m_align.sv -----
module b32m_align import b32m_pkg::*; (
  input  logic [ProdW-1:0] prod_i,
  input  logic [9:0]       exp_sum_i,
  output logic [ProdW-1:0] mant_o,
  output logic             guard_o,
  output logic             sticky_o,
  output logic             normal_o,
  output logic signed [11:0] expo_o
);
  logic [5:0]         lead;
  logic signed [11:0] expo, shift;
  logic [6:0]         s;
  logic [ProdW-1:0]   mask;

  always_comb begin
    lead  = lead_idx(prod_i);
    expo  = 12'(lead) + 12'(exp_sum_i) - 12'sd173;
    normal_o = expo >= 12'sd1;
    shift = 12'(lead) - 12'sd23 + (normal_o ? 12'sd0 : (12'sd1 - expo));
    mant_o   = '0;
    guard_o  = 1'b0;
    sticky_o = 1'b0;
    mask     = '0;
    s        = '0;
    if (shift <= 12'sd0) begin
      mant_o = prod_i << 6'(-shift);
    end else if (shift > 12'sd47) begin
      sticky_o = prod_i != '0;
      guard_o  = 1'b0;
      if (shift == 12'sd48) guard_o = prod_i[ProdW-1];
      if (shift == 12'sd48) sticky_o = prod_i[ProdW-2:0] != '0;
    end else begin
      s        = 7'(shift);
      mant_o   = prod_i >> s;
      guard_o  = prod_i[6'(s - 7'd1)];
      mask     = (ProdW'(1) << 6'(s - 7'd1)) - ProdW'(1);
      sticky_o = (prod_i & mask) != '0;
    end
    expo_o = expo;
  end
endmodule

// ----- hdl/b32m_round.sv -----
module b32m_round import b32m_pkg::*; (
  input  ctl_t              ctl_i,
  input  logic [ProdW-1:0]  mant_i,
  input  logic              guard_i,
  input  logic              sticky_i,
  input  logic              normal_i,
  input  logic signed [11:0] expo_i,
  output logic [31:0]       product_o,
  output logic              ovf_o,
  output logic              unf_o
);
  logic [24:0]        m;
  logic signed [11:0] e;

  always_comb begin
    m = mant_i[24:0] + 25'(guard_i && (sticky_i || mant_i[0]));
    e = expo_i;
    ovf_o = 1'b0;
    unf_o = 1'b0;
    product_o = '0;
    unique case (ctl_i.spc)
      SPC_NAN_A, SPC_NAN_B: product_o = ctl_i.nan_val;
      SPC_DNAN:             product_o = DefaultNan;
      SPC_INF:              product_o = {ctl_i.sign, InfMag};
      SPC_ZERO:             product_o = {ctl_i.sign, 31'd0};
      default: begin
        if (normal_i) begin
          if (m[24]) begin
            m = m >> 1;
            e = e + 12'sd1;
          end
          if (e >= 12'sd255) begin
            product_o = {ctl_i.sign, InfMag};
            ovf_o     = 1'b1;
          end else begin
            product_o = {ctl_i.sign, e[7:0], m[22:0]};
          end
        end else begin
          product_o = {ctl_i.sign, 7'd0, m[23:0]};
          unf_o     = (guard_i || sticky_i) && !m[23];
        end
      end
    endcase
  end
endmodule

// ----- tb/b32m_checker.sv -----
`timescale 1ns / 1ps

module b32m_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  output int          fail_count_o,
  output int          pending_o,
  output int          products_seen_o
);

  typedef struct packed {
    logic [31:0] product;
    logic        overflowed;
    logic        underflowed;
  } product_t;

  product_t expected_products[$];

  function automatic product_t multiply_binary32(input logic [31:0] a, input logic [31:0] b);
    product_t   r;
    logic [31:0] sgn;
    logic [7:0] ea, eb;
    logic [22:0] fa, fb;
    logic [47:0] prod;
    logic [63:0] mant;
    int lead, expo, shift, xa, xb;
    logic nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, guard, sticky, normal;
    r = '0;
    sgn = (a ^ b) & 32'h8000_0000;
    ea = a[30:23]; eb = b[30:23];
    fa = a[22:0];  fb = b[22:0];
    nan_a = (ea == 8'hFF) && (fa != 0);
    nan_b = (eb == 8'hFF) && (fb != 0);
    inf_a = (ea == 8'hFF) && (fa == 0);
    inf_b = (eb == 8'hFF) && (fb == 0);
    zero_a = (ea == 0) && (fa == 0);
    zero_b = (eb == 0) && (fb == 0);
    if (nan_a) r.product = a | 32'h0040_0000;
    else if (nan_b) r.product = b | 32'h0040_0000;
    else if ((inf_a && zero_b) || (inf_b && zero_a)) r.product = 32'h7FC0_0000;
    else if (inf_a || inf_b) r.product = sgn | 32'h7F80_0000;
    else if (zero_a || zero_b) r.product = sgn;
    else begin
      prod = {24'd0, (ea != 0), fa} * {24'd0, (eb != 0), fb};
      lead = 0;
      for (int i = 0; i < 48; i++) if (prod[i]) lead = i;
      xa = (ea != 0) ? int'(ea) : 1;
      xb = (eb != 0) ? int'(eb) : 1;
      expo = lead + xa + xb - 173;
      normal = expo >= 1;
      shift = lead - 23 + (normal ? 0 : 1 - expo);
      guard = 0; sticky = 0;
      if (shift <= 0) mant = {16'd0, prod} << (-shift);
      else if (shift > 63) begin
        mant = 0; sticky = 1;
      end else begin
        mant = {16'd0, prod} >> shift;
        guard = ({16'd0, prod} >> (shift - 1)) & 1;
        sticky = (shift >= 2) && (({16'd0, prod} & ((64'd1 << (shift - 1)) - 1)) != 0);
      end
      if (guard && (sticky || mant[0])) mant++;
      if (normal) begin
        if (mant[24]) begin
          mant >>= 1; expo++;
        end
        if (expo >= 255) begin
          r.product = sgn | 32'h7F80_0000; r.overflowed = 1;
        end else r.product = sgn | (32'(expo) << 23) | (mant[31:0] & 32'h007F_FFFF);
      end else begin
        r.product = sgn | (mant[31:0] & 32'h00FF_FFFF);
        r.underflowed = (guard || sticky) && (r.product[30:23] == 0);
      end
    end
    return r;
  endfunction

  assign pending_o = expected_products.size();

  initial begin
    fail_count_o = 0;
    products_seen_o = 0;
  end

  always @(posedge clk_i) begin
    product_t got, want;
    if (rst_ni) begin
      // output transaction checked before input pushes: same-cycle pass-through is impossible
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[31:0], m_axis_tdata[32], m_axis_tdata[33]};
        products_seen_o++;
        if (expected_products.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected product, expected none, actual %h ovf %b unf %b",
                   $time, got.product, got.overflowed, got.underflowed);
        end else begin
          want = expected_products.pop_front();
          if (got.product !== want.product)
            $display("%0t: product expected %h actual %h", $time, want.product, got.product);
          if (got.overflowed !== want.overflowed)
            $display("%0t: overflowed expected %b actual %b", $time, want.overflowed,
                     got.overflowed);
          if (got.underflowed !== want.underflowed)
            $display("%0t: underflowed expected %b actual %b", $time, want.underflowed,
                     got.underflowed);
          if (got !== want) fail_count_o++;
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_products.push_back(multiply_binary32(s_axis_tdata[31:0], s_axis_tdata[63:32]));
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int RandomPairs = 950;
  localparam int CycleLimit  = 200000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // operand_a[31:0], operand_b[63:32]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [39:0] m_axis_tdata;        // product[31:0], overflowed[32], underflowed[33]

  int fail_count, pending, products_seen;
  int cycle_count = 0;
  bit steady_phase = 0;   // no idling on either side
  bit hold_off = 0;       // receiver blocked for a long stretch

  always #5 clk_i = ~clk_i;

  binary32_multiplier DUT (.*);

  b32m_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending), .products_seen_o(products_seen)
  );

  // random binary32 pattern biased toward interesting exponents
  function automatic logic [31:0] pick_float();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: v[30:23] = 8'h00;
      1: v[30:23] = 8'hFF;
      2: v[30:23] = 8'(($urandom_range(0, 20)));
      3: v[30:23] = 8'(($urandom_range(230, 254)));
      4: v[30:23] = 8'(($urandom_range(40, 90)));   // products near the subnormal range
      5: v[30:0] = $urandom_range(0, 1) ? 31'd0 : 31'h7F80_0000;
      default: ;
    endcase
    return v;
  endfunction

  // send one transaction, waiting for the handshake; tvalid stays high afterwards
  // so the next transaction can follow without a gap
  task automatic send_pair(input logic [31:0] a, input logic [31:0] b);
    while (!steady_phase && $urandom_range(0, 99) < 29) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tdata  <= {b, a};
    s_axis_tvalid <= 1;
    // tready is stable between the falling and the rising edge
    @(posedge clk_i iff s_axis_tready);
    @(negedge clk_i);
  endtask

  // receiver: random stalls, one long hold-off
  always @(negedge clk_i) begin
    if (hold_off) m_axis_tready <= 0;
    else m_axis_tready <= steady_phase || ($urandom_range(0, 99) >= 29);
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [31:0] dir_a[$], dir_b[$];
    int drain;
    dir_a = '{32'h3F80_0000, 32'h7F7F_FFFF, 32'h0000_0001, 32'h7F80_0000, 32'hFF80_0000,
              32'h7FC0_0001, 32'h3F80_0000, 32'h7F80_0000, 32'h8000_0000, 32'h7F7F_FFFF,
              32'h0080_0000, 32'h3F00_0000, 32'h007F_FFFF, 32'hFFFF_FFFF, 32'h3FC0_0000,
              32'h0000_0001, 32'h3F7F_FFFF, 32'h7FA0_0000, 32'h0000_0000, 32'h807F_FFFF};
    dir_b = '{32'hBF80_0000, 32'h7F7F_FFFF, 32'h0000_0001, 32'h0000_0000, 32'h4000_0000,
              32'h3F80_0000, 32'h7F80_0001, 32'hFF80_0000, 32'h4000_0000, 32'hBF80_0000,
              32'h3F00_0000, 32'h0080_0000, 32'h3F80_0001, 32'h7FFF_FFFF, 32'h3FC0_0000,
              32'h3F00_0000, 32'h0080_0001, 32'h0000_0000, 32'h8000_0000, 32'h4000_0000};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    foreach (dir_a[i]) send_pair(dir_a[i], dir_b[i]);

    for (int n = 0; n < RandomPairs; n++) begin
      steady_phase = (n >= 300 && n < 400);
      if (n == 500) begin
        // receiver blocks while the sender keeps offering
        fork
          begin
            hold_off = 1;
            repeat (60) @(negedge clk_i);
            hold_off = 0;
          end
        join_none
      end
      if ($urandom_range(0, 3) == 0) send_pair($urandom, $urandom);
      else send_pair(pick_float(), pick_float());
    end
    s_axis_tvalid <= 0;
    steady_phase = 0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d products: directed specials, random operands with gaps, stalls",
             products_seen);
    $display("including a long output hold-off and a stretch of back-to-back transactions");
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
